/* rtl/tcw_pkg.sv */
// Shared types and codes for the text console writer.
// No dependencies; imported by the top level and its checker.
package tcw_pkg;

    typedef logic [1:0]  op_t;
    typedef logic [7:0]  char_t;
    typedef logic [6:0]  col_t;
    typedef logic [4:0]  row_t;
    typedef logic [10:0] lin_pos_t;
    typedef logic [15:0] cell_t;
    typedef logic [7:0]  attr_t;
    typedef logic [1:0]  reg_idx_t;

    localparam op_t OP_PUT    = 2'd0;
    localparam op_t OP_READ   = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;
    localparam op_t OP_SETCUR = 2'd3;

    localparam reg_idx_t REG_COLUMNS   = 2'd0;
    localparam reg_idx_t REG_ROWS      = 2'd1;
    localparam reg_idx_t REG_ATTRIBUTE = 2'd2;

    localparam char_t CH_BS    = 8'h08;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;

    localparam col_t  COLUMNS_RESET = 7'd80;
    localparam row_t  ROWS_RESET    = 5'd25;
    localparam attr_t ATTR_RESET    = 8'h0F;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_BLANK,
        ST_READ,
        ST_READ_WAIT,
        ST_SCR_SETUP,
        ST_SCR_COPY,
        ST_CLR_SETUP,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

/* rtl/text_console_writer.sv */
// Text console writer: character-cell store with cursor, scroll and clear.
// Depends on tcw_pkg; one sequencer around a shared column + columns*row unit.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  cfg      | cfg_wr_en          | cfg_index, cfg_wdata
//  s_ (in)  | s_valid / s_ready  | s_opcode, s_char_code, s_col, s_row
//  m_ (out) | m_valid / m_ready  | m_status, m_cursor_col, m_cursor_row,
//           |                    | m_cursor_position, m_cell_value
//
// Set cursor and rejected reads go straight to the result step; a read passes through
// ST_READ and ST_READ_WAIT; a backspace moves the cursor, then blanks the cell; a tab
// writes TAB_SPACES spaces. Scroll copies each row one row up and blanks the last row,
// clear blanks every cell of the screen in use; both walk the store one cell a cycle
// through its single read and write port. After reset the store is zeroed with s_ready low.
// A result waiting in the output register holds the next item at its last step.
module text_console_writer #(
    parameter int MAX_COLS   = 80,
    parameter int MAX_ROWS   = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  tcw_pkg::reg_idx_t  cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::op_t       s_opcode,
    input  tcw_pkg::char_t     s_char_code,
    input  tcw_pkg::col_t      s_col,
    input  tcw_pkg::row_t      s_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output tcw_pkg::col_t      m_cursor_col,
    output tcw_pkg::row_t      m_cursor_row,
    output tcw_pkg::lin_pos_t  m_cursor_position,
    output tcw_pkg::cell_t     m_cell_value
);
    import tcw_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = (ADDR_W + 1 > 12) ? ADDR_W + 1 : 12;
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [POS_W-1:0]  sweep_reg, sweep_next;
    logic [POS_W-1:0]  limit_reg, limit_next;
    logic              pend_reg, pend_next;
    logic [POS_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [TAB_W-1:0]  tab_reg, tab_next;
    col_t              cur_col_reg, cur_col_next;
    row_t              cur_line_reg, cur_line_next;
    col_t              columns_reg, columns_next;
    row_t              rows_reg, rows_next;
    attr_t             attr_reg, attr_next;
    logic              m_valid_reg, m_valid_next;

    char_t             ch_reg, ch_next;
    col_t              col_reg, col_next;
    row_t              row_reg, row_next;
    logic              status_reg, status_next;
    cell_t             cell_reg, cell_next;
    logic              m_status_reg, m_status_next;
    col_t              m_col_reg, m_col_next;
    row_t              m_row_reg, m_row_next;
    lin_pos_t          m_pos_reg, m_pos_next;
    cell_t             m_cell_reg, m_cell_next;

    cell_t             mem [DEPTH];
    cell_t             rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    cell_t             mem_wdata;

    col_t              nc;
    row_t              nr;
    col_t              unit_col;
    row_t              unit_line;
    logic [POS_W-1:0]  unit_sum;
    logic              out_free, accept;
    cell_t             blank;

    // clamp the registers to the geometry the store supports
    assign nc = (columns_reg == '0) ? 7'd1 :
                (32'(columns_reg) > MAX_COLS) ? 7'(MAX_COLS) : columns_reg;
    assign nr = (rows_reg == '0) ? 5'd1 :
                (32'(rows_reg) > MAX_ROWS) ? 5'(MAX_ROWS) : rows_reg;

    assign blank    = {attr_reg, CH_SPACE};
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept   = s_valid && s_ready;

    // shared index unit: column + columns * row
    always_comb begin
        case (state_reg)
            ST_SCR_SETUP, ST_CLR_SETUP: begin
                unit_col  = nc;
                unit_line = 5'(nr - 5'd1);
            end
            ST_READ: begin
                unit_col  = col_reg;
                unit_line = row_reg;
            end
            default: begin
                unit_col  = cur_col_reg;
                unit_line = cur_line_reg;
            end
        endcase
    end

    assign unit_sum = POS_W'(unit_col) + POS_W'(nc) * POS_W'(unit_line);

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        sweep_next     = sweep_reg;
        limit_next     = limit_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        tab_next       = tab_reg;
        cur_col_next   = cur_col_reg;
        cur_line_next  = cur_line_reg;
        ch_next        = ch_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        status_next    = status_reg;
        cell_next      = cell_reg;
        m_status_next  = m_status_reg;
        m_col_next     = m_col_reg;
        m_row_next     = m_row_reg;
        m_pos_next     = m_pos_reg;
        m_cell_next    = m_cell_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_waddr      = unit_sum[ADDR_W-1:0];
        mem_wdata      = blank;
        mem_re         = 1'b0;
        mem_raddr      = unit_sum[ADDR_W-1:0];

        columns_next = (cfg_wr_en && cfg_index == REG_COLUMNS) ? cfg_wdata[6:0] : columns_reg;
        rows_next    = (cfg_wr_en && cfg_index == REG_ROWS) ? cfg_wdata[4:0] : rows_reg;
        attr_next    = (cfg_wr_en && cfg_index == REG_ATTRIBUTE) ? cfg_wdata : attr_reg;

        case (state_reg)
            ST_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[ADDR_W-1:0];
                mem_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == POS_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUT: begin
                if (cur_col_reg >= nc) begin
                    // wrap before handling the byte
                    cur_col_next = '0;
                    if (6'(cur_line_reg) + 6'd1 < 6'(nr)) begin
                        cur_line_next = cur_line_reg + 1'b1;
                    end else begin
                        cur_line_next = 5'(nr - 5'd1);
                        ret_next      = ST_PUT;
                        state_next    = ST_SCR_SETUP;
                    end
                end else begin
                    case (ch_reg)
                        CH_LF: begin
                            cur_col_next = '0;
                            if (6'(cur_line_reg) + 6'd1 < 6'(nr)) begin
                                cur_line_next = cur_line_reg + 1'b1;
                                state_next    = ST_DONE;
                            end else begin
                                cur_line_next = 5'(nr - 5'd1);
                                ret_next      = ST_DONE;
                                state_next    = ST_SCR_SETUP;
                            end
                        end
                        CH_CR: begin
                            cur_col_next = '0;
                            state_next   = ST_DONE;
                        end
                        CH_BS: begin
                            if (cur_col_reg == '0 && cur_line_reg != '0) begin
                                cur_line_next = cur_line_reg - 1'b1;
                                cur_col_next  = 7'(nc - 7'd1);
                            end else if (cur_col_reg != '0) begin
                                cur_col_next = cur_col_reg - 1'b1;
                            end
                            state_next = ST_BLANK;
                        end
                        CH_TAB: begin
                            ch_next  = CH_SPACE;
                            tab_next = TAB_W'(TAB_SPACES);
                        end
                        default: begin
                            mem_we       = 1'b1;
                            mem_wdata    = {attr_reg, ch_reg};
                            cur_col_next = cur_col_reg + 1'b1;
                            if (tab_reg > TAB_W'(1)) begin
                                tab_next = tab_reg - 1'b1;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_BLANK: begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                cell_next  = rdata_reg;
                state_next = ST_DONE;
            end
            ST_SCR_SETUP: begin
                limit_next = unit_sum;
                sweep_next = POS_W'(nc);
                pend_next  = 1'b0;
                state_next = ST_SCR_COPY;
            end
            ST_SCR_COPY: begin
                // read one row ahead, write the word back one row up
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg[ADDR_W-1:0];
                    mem_wdata = rdata_reg;
                end
                if (sweep_reg < limit_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = sweep_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = sweep_reg - POS_W'(nc);
                    sweep_next     = sweep_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        sweep_next = limit_reg - POS_W'(nc);
                        state_next = ST_FILL;
                    end
                end
            end
            ST_CLR_SETUP: begin
                limit_next = unit_sum;
                sweep_next = '0;
                ret_next   = ST_DONE;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[ADDR_W-1:0];
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg + 1'b1 >= limit_reg) begin
                    state_next = ret_reg;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_col_next    = cur_col_reg;
                    m_row_next    = cur_line_reg;
                    m_pos_next    = unit_sum[10:0];
                    m_cell_next   = cell_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        if (accept) begin
            ch_next     = s_char_code;
            col_next    = s_col;
            row_next    = s_row;
            tab_next    = '0;
            status_next = 1'b0;
            cell_next   = '0;
            case (s_opcode)
                OP_PUT: begin
                    if (cur_line_reg >= nr) begin
                        cur_line_next = 5'(nr - 5'd1);
                    end
                    state_next = ST_PUT;
                end
                OP_READ: begin
                    if (s_col < nc && s_row < nr) begin
                        state_next = ST_READ;
                    end else begin
                        status_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
                OP_CLEAR: begin
                    cur_col_next  = '0;
                    cur_line_next = '0;
                    state_next    = ST_CLR_SETUP;
                end
                OP_SETCUR: begin
                    if (s_col <= nc && s_row < nr) begin
                        cur_col_next  = s_col;
                        cur_line_next = s_row;
                    end else begin
                        status_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                default: begin
                    state_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            ret_reg       <= ST_DONE;
            sweep_reg     <= '0;
            limit_reg     <= '0;
            pend_reg      <= 1'b0;
            tab_reg       <= '0;
            cur_col_reg   <= '0;
            cur_line_reg  <= '0;
            columns_reg   <= COLUMNS_RESET;
            rows_reg      <= ROWS_RESET;
            attr_reg      <= ATTR_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            sweep_reg     <= sweep_next;
            limit_reg     <= limit_next;
            pend_reg      <= pend_next;
            tab_reg       <= tab_next;
            cur_col_reg   <= cur_col_next;
            cur_line_reg  <= cur_line_next;
            columns_reg   <= columns_next;
            rows_reg      <= rows_next;
            attr_reg      <= attr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        ch_reg        <= ch_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        status_reg    <= status_next;
        cell_reg      <= cell_next;
        m_status_reg  <= m_status_next;
        m_col_reg     <= m_col_next;
        m_row_reg     <= m_row_next;
        m_pos_reg     <= m_pos_next;
        m_cell_reg    <= m_cell_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_cursor_col      = m_col_reg;
    assign m_cursor_row      = m_row_reg;
    assign m_cursor_position = m_pos_reg;
    assign m_cell_value      = m_cell_reg;

endmodule

/* rtl/tcw_checker.sv */
// Port-level assertions for the text console writer, bound to the top level.
// Depends on tcw_pkg for the port types.
module tcw_checker #(
    parameter int MAX_ROWS = 25
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_status,
    input tcw_pkg::col_t      m_cursor_col,
    input tcw_pkg::row_t      m_cursor_row,
    input tcw_pkg::lin_pos_t  m_cursor_position,
    input tcw_pkg::cell_t     m_cell_value
);
    import tcw_pkg::*;

    // reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output or input open right after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_cursor_col)
            && $stable(m_cursor_row) && $stable(m_cursor_position)
            && $stable(m_cell_value))
        else $error("stalled result changed");

    a_reject_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_cell_value == '0)
        else $error("rejected operation returned cell data");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_cursor_row) < MAX_ROWS)
        else $error("cursor row beyond the store");

endmodule

bind text_console_writer tcw_checker #(.MAX_ROWS(MAX_ROWS)) u_tcw_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking bench for text_console_writer: directed and random console traffic.
// Depends on tcw_pkg and the text_console_writer RTL; a shadow screen predicts each result.
module tb_top;
    import tcw_pkg::*;

    localparam int GRID_COLS   = 80;
    localparam int GRID_ROWS   = 25;
    localparam int TAB_WIDTH   = 4;
    localparam int STORE_CELLS = GRID_COLS * GRID_ROWS;
    localparam int MAX_IDLE    = 17;

    typedef struct packed {
        op_t   opcode;
        char_t ch;
        col_t  col;
        row_t  row;
    } console_cmd_t;

    typedef struct packed {
        logic     status;
        col_t     col;
        row_t     row;
        lin_pos_t pos;
        cell_t    cell_val;
    } console_result_t;

    // Shadow copy of the screen and cursor; queues the cursor report of every command.
    class console_tracker;
        cell_t           cells [STORE_CELLS];
        int unsigned     cur_col;
        int unsigned     cur_line;
        col_t            columns_reg;
        row_t            rows_reg;
        attr_t           attr_reg;
        console_result_t expected_q [$];
        int unsigned     fail_count;
        int unsigned     result_count;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cur_col      = 0;
            cur_line     = 0;
            columns_reg  = COLUMNS_RESET;
            rows_reg     = ROWS_RESET;
            attr_reg     = ATTR_RESET;
            fail_count   = 0;
            result_count = 0;
        endfunction

        function int unsigned width_in_use();
            if (columns_reg < 1) return 1;
            if (columns_reg > GRID_COLS) return GRID_COLS;
            return 32'(columns_reg);
        endfunction

        function int unsigned height_in_use();
            if (rows_reg < 1) return 1;
            if (rows_reg > GRID_ROWS) return GRID_ROWS;
            return 32'(rows_reg);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_register(reg_idx_t idx, logic [7:0] data);
            case (idx)
                REG_COLUMNS:   columns_reg = data[6:0];
                REG_ROWS:      rows_reg    = data[4:0];
                REG_ATTRIBUTE: attr_reg    = data;
                default: ;
            endcase
        endfunction

        function cell_t blank_cell();
            return {attr_reg, CH_SPACE};
        endfunction

        function void store_cell(int unsigned c, int unsigned r, cell_t v);
            int unsigned idx;
            idx = c + width_in_use() * r;
            if (idx < STORE_CELLS) cells[idx] = v;
        endfunction

        // Next line; at the bottom, shift every row up and blank the last one.
        function void line_feed();
            int unsigned nc;
            int unsigned nr;
            nc = width_in_use();
            nr = height_in_use();
            cur_col = 0;
            if (cur_line + 1 < nr) begin
                cur_line++;
                return;
            end
            for (int unsigned r = 1; r < nr; r++)
                for (int unsigned c = 0; c < nc; c++)
                    cells[c + nc * (r - 1)] = cells[c + nc * r];
            for (int unsigned c = 0; c < nc; c++) store_cell(c, nr - 1, blank_cell());
            cur_line = nr - 1;
        endfunction

        function void wrap_if_full();
            if (cur_col >= width_in_use()) line_feed();
        endfunction

        function void print_cell(char_t ch);
            store_cell(cur_col, cur_line, {attr_reg, ch});
            cur_col++;
        endfunction

        function void put_char(char_t ch);
            wrap_if_full();
            case (ch)
                CH_LF: line_feed();
                CH_CR: cur_col = 0;
                CH_BS: begin
                    if (cur_col == 0 && cur_line >= 1) begin
                        cur_line--;
                        cur_col = width_in_use();
                    end
                    if (cur_col >= 1) cur_col--;
                    store_cell(cur_col, cur_line, blank_cell());
                end
                CH_TAB: begin
                    repeat (TAB_WIDTH) begin
                        wrap_if_full();
                        print_cell(CH_SPACE);
                    end
                end
                default: print_cell(ch);
            endcase
        endfunction

        function void note_command(console_cmd_t cmd);
            console_result_t want;
            int unsigned     nc;
            int unsigned     nr;
            nc   = width_in_use();
            nr   = height_in_use();
            want = '0;
            case (cmd.opcode)
                OP_PUT: begin
                    if (cur_line >= nr) cur_line = nr - 1;
                    put_char(cmd.ch);
                end
                OP_READ: begin
                    if (cmd.col < nc && cmd.row < nr)
                        want.cell_val = cells[cmd.col + nc * cmd.row];
                    else want.status = 1'b1;
                end
                OP_CLEAR: begin
                    for (int unsigned r = 0; r < nr; r++)
                        for (int unsigned c = 0; c < nc; c++) store_cell(c, r, blank_cell());
                    cur_col  = 0;
                    cur_line = 0;
                end
                default: begin
                    if (cmd.col <= nc && cmd.row < nr) begin
                        cur_col  = 32'(cmd.col);
                        cur_line = 32'(cmd.row);
                    end else begin
                        want.status = 1'b1;
                    end
                end
            endcase
            want.col = col_t'(cur_col);
            want.row = row_t'(cur_line);
            want.pos = lin_pos_t'(cur_col + nc * cur_line);
            expected_q.push_back(want);
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            result_count++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"result %0d arrived with nothing expected: ",
                              "st=%0d col=%0d row=%0d pos=%0d cell=%h"},
                             result_count, got.status, got.col, got.row, got.pos,
                             got.cell_val);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.col !== want.col || got.row !== want.row ||
                got.pos !== want.pos || got.cell_val !== want.cell_val) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"result %0d: got st=%0d col=%0d row=%0d pos=%0d cell=%h, ",
                              "want st=%0d col=%0d row=%0d pos=%0d cell=%h"},
                             result_count, got.status, got.col, got.row, got.pos,
                             got.cell_val, want.status, want.col, want.row, want.pos,
                             want.cell_val);
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    reg_idx_t   cfg_index   = REG_COLUMNS;
    logic [7:0] cfg_wdata   = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    op_t        s_opcode    = OP_PUT;
    char_t      s_char_code = '0;
    col_t       s_col       = '0;
    row_t       s_row       = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_status;
    col_t       m_cursor_col;
    row_t       m_cursor_row;
    lin_pos_t   m_cursor_position;
    cell_t      m_cell_value;

    bit             send_idle = 1'b1;
    bit             recv_idle = 1'b1;
    console_tracker tracker;

    text_console_writer #(
        .MAX_COLS   (GRID_COLS),
        .MAX_ROWS   (GRID_ROWS),
        .TAB_SPACES (TAB_WIDTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_char_code       (s_char_code),
        .s_col             (s_col),
        .s_row             (s_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_position (m_cursor_position),
        .m_cell_value      (m_cell_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            tracker.check_result({m_status, m_cursor_col, m_cursor_row,
                                  m_cursor_position, m_cell_value});
    end

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    function automatic console_cmd_t make_cmd(op_t op, char_t ch, col_t c, row_t r);
        console_cmd_t cmd;
        cmd.opcode = op;
        cmd.ch     = ch;
        cmd.col    = c;
        cmd.row    = r;
        return cmd;
    endfunction

    // Mostly text with control bytes, cursor moves and reads in range; some noise.
    function automatic console_cmd_t draw_command(bit wide_screen);
        console_cmd_t cmd;
        int unsigned  roll;
        int unsigned  pick;
        int unsigned  nc;
        int unsigned  nr;
        nc   = tracker.width_in_use();
        nr   = tracker.height_in_use();
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        cmd  = make_cmd(op_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
                        col_t'($urandom_range(0, 127)), row_t'($urandom_range(0, 31)));
        if (roll < 62) begin
            cmd.opcode = OP_PUT;
            if (pick < 70)      cmd.ch = char_t'($urandom_range(32, 126));
            else if (pick < 78) cmd.ch = CH_LF;
            else if (pick < 84) cmd.ch = CH_CR;
            else if (pick < 90) cmd.ch = CH_BS;
            else if (pick < 95) cmd.ch = CH_TAB;
        end else if (roll < 77) begin
            cmd.opcode = OP_READ;
            if (pick < 85) begin
                cmd.col = col_t'($urandom_range(0, nc - 1));
                cmd.row = row_t'($urandom_range(0, nr - 1));
            end
        end else if (roll < 92) begin
            cmd.opcode = OP_SETCUR;
            if (pick < 85) begin
                cmd.col = col_t'($urandom_range(0, nc));
                cmd.row = row_t'($urandom_range(0, nr - 1));
            end
        end else if (roll < (wide_screen ? 94 : 96)) begin
            cmd.opcode = OP_CLEAR;
        end
        return cmd;
    endfunction

    task automatic send_command(console_cmd_t cmd);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= cmd.opcode;
        s_char_code <= cmd.ch;
        s_col       <= cmd.col;
        s_row       <= cmd.row;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_command(cmd);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // Write all three registers; unused upper data bits get random values.
    task automatic program_screen(int unsigned cols, int unsigned lines, attr_t attr);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_wdata <= {1'($urandom_range(0, 1)), 7'(cols)};
        tracker.set_register(REG_COLUMNS, {1'b0, 7'(cols)});
        @(posedge aclk);
        cfg_index <= REG_ROWS;
        cfg_wdata <= {3'($urandom_range(0, 7)), 5'(lines)};
        tracker.set_register(REG_ROWS, {3'b0, 5'(lines)});
        @(posedge aclk);
        cfg_index <= REG_ATTRIBUTE;
        cfg_wdata <= attr;
        tracker.set_register(REG_ATTRIBUTE, attr);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        console_cmd_t script [$];
        int unsigned  cols;
        int unsigned  lines;
        attr_t        attr;
        bit           wide_screen;
        int           n_items;

        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks at the reset geometry of 80 x 25.
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd79,  5'd24));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd80,  5'd0));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd0,   5'd25));
        script.push_back(make_cmd(OP_READ,   8'hFF,  7'd127, 5'd31));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd80,  5'd0));
        script.push_back(make_cmd(OP_PUT,    8'h41,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd0,   5'd1));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd0,   5'd25));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd81,  5'd0));
        script.push_back(make_cmd(OP_PUT,    8'h00,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    8'hFF,  7'd127, 5'd31));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    CH_BS,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd0,   5'd1));
        script.push_back(make_cmd(OP_PUT,    CH_BS,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd78,  5'd3));
        script.push_back(make_cmd(OP_PUT,    CH_TAB, 7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    CH_CR,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    CH_LF,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd79,  5'd24));
        script.push_back(make_cmd(OP_PUT,    8'h5A,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    8'h59,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_PUT,    CH_LF,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd0,   5'd23));
        script.push_back(make_cmd(OP_CLEAR,  8'h00,  7'd0,   5'd0));
        script.push_back(make_cmd(OP_READ,   8'h00,  7'd5,   5'd5));
        // Leave the cursor far down so the next, smaller screen must pull it in.
        script.push_back(make_cmd(OP_SETCUR, 8'h00,  7'd80,  5'd20));
        foreach (script[i]) send_command(script[i]);
        drain_results();

        for (int phase = 0; phase < 17; phase++) begin
            attr = attr_t'($urandom_range(0, 255));
            case (phase)
                0:       begin cols = 10;  lines = 3;  attr = 8'h00; end
                1:       begin cols = 1;   lines = 1;  attr = 8'hFF; end
                2:       begin cols = 0;   lines = 0;  end
                3:       begin cols = 127; lines = 31; end
                4:       begin cols = 80;  lines = 25; end
                5:       begin cols = 1;   lines = 25; end
                6:       begin cols = 80;  lines = 1;  end
                default: begin
                    cols  = $urandom_range(1, 16);
                    lines = $urandom_range(1, 8);
                end
            endcase
            program_screen(cols, lines, attr);
            wide_screen = tracker.width_in_use() * tracker.height_in_use() > 400;
            n_items     = wide_screen ? 40 : 122;
            send_idle   = $urandom_range(0, 2) != 0;
            recv_idle   = $urandom_range(0, 2) != 0;

            // Open with a put so a cursor left outside the new screen gets pulled in.
            send_command(make_cmd(OP_PUT, char_t'($urandom_range(32, 126)), '0, '0));
            repeat (n_items) begin
                if ($urandom_range(0, 49) == 0) drain_results();
                send_command(draw_command(wide_screen));
            end
            drain_results();
        end

        repeat (60) @(posedge aclk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/sv/tb_top.sv
